// ===== rtl/hre_pkg.sv =====
// Package with the shared constants and tables of the Hessian eigen block.
package hre_pkg;

  // Number of vectoring CORDIC iterations, one pipeline stage each.
  localparam int CORDIC_STEPS = 32;

  // CORDIC datapath width: operands are scaled up to 2^61 and grow by the gain.
  localparam int CORDIC_WIDTH = 65;

  // Scaled CORDIC operands sit with their top bit at this position.
  localparam int CORDIC_TOP = 61;

  // Accumulated angle width, in units of 2^-32 turn, signed.
  localparam int ANGLE_ACC_WIDTH = 34;

  localparam logic [31:0] PHI_EIGHTH  = 32'h2000_0000;
  localparam logic [31:0] PHI_QUARTER = 32'h4000_0000;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Per-item control flags carried down the pipeline.
  typedef struct packed {
    logic rc_zero;
    logic d_zero;
    logic e1_hi;
  } hre_flags_t;

endpackage

// ===== rtl/hre_if.sv =====
// Channel interfaces for the Hessian eigen block: derivative input and eigen result.
interface hre_in_if #(
  parameter int DERIV_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [DERIV_WIDTH-1:0] second_deriv_yy;
  logic signed [DERIV_WIDTH-1:0] second_deriv_xy;
  logic signed [DERIV_WIDTH-1:0] second_deriv_xx;

  modport source (output valid, second_deriv_yy, second_deriv_xy, second_deriv_xx,
                  input ready);
  modport sink (input valid, second_deriv_yy, second_deriv_xy, second_deriv_xx,
                output ready);
endinterface

interface hre_out_if #(
  parameter int DERIV_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [DERIV_WIDTH+1:0] major_eigenvalue;
  logic signed [DERIV_WIDTH+1:0] minor_eigenvalue;
  logic        [DERIV_WIDTH:0]   ridge_strength;
  logic        [ANGLE_WIDTH-1:0] normal_angle;

  modport source (output valid, major_eigenvalue, minor_eigenvalue, ridge_strength,
                  normal_angle, input ready);
  modport sink (input valid, major_eigenvalue, minor_eigenvalue, ridge_strength,
                normal_angle, output ready);
endinterface

// ===== rtl/hessian_ridge_eigen.sv =====
// Hessian eigen decomposition: pipelined closed-form Jacobi rotation with CORDIC angle.
// The pipeline has DERIV_WIDTH + 39 register stages (63 at the default). It takes one
// request per cycle while it advances: every stage is registered and the whole pipeline
// advances together whenever the output register is empty or its result is being taken.
// A synchronous active-low reset clears only the stage valid bits; data registers keep
// whatever they held, which is harmless because nothing is presented without its valid bit.
module hessian_ridge_eigen #(
  parameter int DERIV_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  hre_in_if.sink    in_chan,
  hre_out_if.source out_chan
);
  import hre_pkg::*;

  // Derived widths. The square root works on a radicand of 2*K bits and yields K bits.
  localparam int W   = DERIV_WIDTH;
  localparam int K   = W + 1;
  localparam int NW  = 2 * K;
  localparam int RW  = K + 2;
  localparam int P   = CORDIC_TOP - W;
  localparam int CW  = CORDIC_WIDTH;
  localparam int ZW  = ANGLE_ACC_WIDTH;
  // Stage map: operand prep, squares, sum, K root steps, rotation, ordering,
  // CORDIC_STEPS angle steps, output register.
  localparam int NST = K + CORDIC_STEPS + 6;

  // One enable for the whole pipeline: it moves whenever the output can move.
  logic           en;
  logic [NST-1:0] vld_r;

  assign en            = !vld_r[NST-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_chan.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: trace, difference and the magnitudes that feed the root.
  // S = yy + xx, D = xx - yy; the root argument is D^2 + (2*xy)^2.
  // ---------------------------------------------------------------------------
  logic signed [W:0]   s1_s_nxt, s1_s_r;
  logic signed [W:0]   d_w;
  logic signed [W+1:0] y2_w;
  logic        [W:0]   s1_ad_nxt, s1_ad_r, s1_ay_nxt, s1_ay_r;
  logic signed [W+1:0] s1_ys_nxt, s1_ys_r;
  hre_flags_t          s1_f_nxt, s1_f_r;

  always_comb begin
    s1_s_nxt  = W'(0) + ({in_chan.second_deriv_yy[W-1], in_chan.second_deriv_yy} +
                         {in_chan.second_deriv_xx[W-1], in_chan.second_deriv_xx});
    d_w       = {in_chan.second_deriv_xx[W-1], in_chan.second_deriv_xx} -
                {in_chan.second_deriv_yy[W-1], in_chan.second_deriv_yy};
    y2_w      = {in_chan.second_deriv_xy[W-1], in_chan.second_deriv_xy, 1'b0};
    s1_ad_nxt = d_w[W] ? W'(0) + (~d_w + 1'b1) : d_w;
    s1_ay_nxt = y2_w[W+1] ? (W+1)'(-y2_w) : y2_w[W:0];
    // The CORDIC works in the right half plane, so the cross term is negated when D is negative.
    s1_ys_nxt = d_w[W] ? -y2_w : y2_w;
    s1_f_nxt.rc_zero = (in_chan.second_deriv_xy == '0);
    s1_f_nxt.d_zero  = (d_w == '0);
    s1_f_nxt.e1_hi   = d_w[W] || ((d_w == '0) && in_chan.second_deriv_xy[W-1]);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the two squares, each on its own multiplier.
  // ---------------------------------------------------------------------------
  logic        [2*W+1:0] s2_sqd_r, s2_sqy_r;
  logic signed [W:0]     s2_s_r;
  logic        [W:0]     s2_ad_r;
  logic signed [W+1:0]   s2_ys_r;
  hre_flags_t            s2_f_r;

  // ---------------------------------------------------------------------------
  // Square root: index 0 holds the radicand after the sum stage, each later
  // index one restoring step that settles one bit of the root.
  // ---------------------------------------------------------------------------
  logic        [NW-1:0] rt_rad_r [0:K];
  logic        [RW-1:0] rt_rem_r [0:K];
  logic        [K-1:0]  rt_q_r   [0:K];
  logic signed [W:0]    rt_s_r   [0:K];
  logic        [W:0]    rt_ad_r  [0:K];
  logic signed [W+1:0]  rt_ys_r  [0:K];
  hre_flags_t           rt_f_r   [0:K];

  logic        [NW-1:0] rt_rad_nxt [0:K-1];
  logic        [RW-1:0] rt_rem_nxt [0:K-1];
  logic        [K-1:0]  rt_q_nxt   [0:K-1];

  for (genvar j = 0; j < K; j++) begin : g_root
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    always_comb begin
      rem_sh        = {rt_rem_r[j][K-1:0], rt_rad_r[j][NW-1 -: 2]};
      trial         = {rt_q_r[j], 2'b01};
      rt_rad_nxt[j] = {rt_rad_r[j][NW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rt_rem_nxt[j] = rem_sh - trial;
        rt_q_nxt[j]   = {rt_q_r[j][K-2:0], 1'b1};
      end else begin
        rt_rem_nxt[j] = rem_sh;
        rt_q_nxt[j]   = {rt_q_r[j][K-2:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Rotation stage: the rotated diagonal terms are floor((S -/+ R) / 2).
  // Which of them is e1 depends on the sign of D, or of the cross term when D is zero.
  // ---------------------------------------------------------------------------
  logic signed [W+2:0] sum_hi_w, sum_lo_w;
  logic signed [W+1:0] e1_nxt, e2_nxt, e1_r, e2_r;
  logic        [W:0]   re_ad_r;
  logic signed [W+1:0] re_ys_r;
  hre_flags_t          re_f_r;

  always_comb begin
    sum_hi_w = {{2{rt_s_r[K][W]}}, rt_s_r[K]} + {2'b00, rt_q_r[K]};
    sum_lo_w = {{2{rt_s_r[K][W]}}, rt_s_r[K]} - {2'b00, rt_q_r[K]};
    if (rt_f_r[K].e1_hi) begin
      e1_nxt = sum_hi_w[W+2:1];
      e2_nxt = sum_lo_w[W+2:1];
    end else begin
      e1_nxt = sum_lo_w[W+2:1];
      e2_nxt = sum_hi_w[W+2:1];
    end
  end

  // ---------------------------------------------------------------------------
  // Ordering stage: the term of larger magnitude is major; on a tie, the smaller.
  // ---------------------------------------------------------------------------
  logic        [W+1:0] m1_w, m2_w;
  logic                e1_major_w;
  logic signed [W+1:0] od_maj_nxt, od_min_nxt, od_maj_r, od_min_r;
  logic                od_e1m_r;
  logic        [W:0]   od_ad_r;
  logic signed [W+1:0] od_ys_r;
  hre_flags_t          od_f_r;

  always_comb begin
    m1_w       = e1_r[W+1] ? (W+2)'(-e1_r) : e1_r;
    m2_w       = e2_r[W+1] ? (W+2)'(-e2_r) : e2_r;
    e1_major_w = (m1_w > m2_w) || ((m1_w == m2_w) && (e1_r < e2_r));
    od_maj_nxt = e1_major_w ? e1_r : e2_r;
    od_min_nxt = e1_major_w ? e2_r : e1_r;
  end

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC: the first step takes the scaled operand pair straight from
  // the ordering stage, each index of the arrays below is one registered step.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] co_x0_w, co_y0_w;

  logic signed [CW-1:0] co_x_r   [1:CORDIC_STEPS];
  logic signed [CW-1:0] co_y_r   [1:CORDIC_STEPS];
  logic signed [ZW-1:0] co_z_r   [1:CORDIC_STEPS];
  logic signed [W+1:0]  co_maj_r [1:CORDIC_STEPS];
  logic signed [W+1:0]  co_min_r [1:CORDIC_STEPS];
  logic                 co_e1m_r [1:CORDIC_STEPS];
  hre_flags_t           co_f_r   [1:CORDIC_STEPS];

  logic signed [CW-1:0] co_x_nxt [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] co_y_nxt [0:CORDIC_STEPS-1];
  logic signed [ZW-1:0] co_z_nxt [0:CORDIC_STEPS-1];

  // Both operands scaled so their top sits at 2^61.
  assign co_x0_w = {{(CW-(W+1)-P){1'b0}}, od_ad_r, {P{1'b0}}};
  assign co_y0_w = {{(CW-(W+2)-P){od_ys_r[W+1]}}, od_ys_r, {P{1'b0}}};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in, step;
    if (i == 0) begin : g_first
      assign x_in = co_x0_w;
      assign y_in = co_y0_w;
      assign z_in = '0;
    end else begin : g_next
      assign x_in = co_x_r[i];
      assign y_in = co_y_r[i];
      assign z_in = co_z_r[i];
    end
    always_comb begin
      dx   = y_in >>> i;
      dy   = x_in >>> i;
      step = {{(ZW-32){1'b0}}, ATAN_TURNS[i]};
      if (!y_in[CW-1]) begin
        co_x_nxt[i] = x_in + dx;
        co_y_nxt[i] = y_in - dy;
        co_z_nxt[i] = z_in + step;
      end else begin
        co_x_nxt[i] = x_in - dx;
        co_y_nxt[i] = y_in + dy;
        co_z_nxt[i] = z_in - step;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: the rotation angle is half the CORDIC angle, with the fixed
  // cases for a zero cross term and a zero difference. A minor e1 turns the
  // normal by a quarter; the angle is then rounded to ANGLE_WIDTH bits of a turn.
  // ---------------------------------------------------------------------------
  localparam int LAST = CORDIC_STEPS;

  logic [31:0]             phi_w, ang_w;
  logic [32:0]             rnd_w;
  logic [ANGLE_WIDTH-1:0]  angle_nxt, angle_r;
  logic signed [W+1:0]     major_r, minor_r;
  logic [W:0]              ridge_nxt, ridge_r;

  always_comb begin
    priority if (co_f_r[LAST].rc_zero) begin
      phi_w = '0;
    end else if (co_f_r[LAST].d_zero) begin
      phi_w = PHI_EIGHTH;
    end else begin
      phi_w = co_z_r[LAST][32:1];
    end
    ang_w     = co_e1m_r[LAST] ? phi_w : phi_w - PHI_QUARTER;
    rnd_w     = {1'b0, ang_w} + (33'd1 << (31 - ANGLE_WIDTH));
    angle_nxt = rnd_w[31 -: ANGLE_WIDTH];
    ridge_nxt = (!co_maj_r[LAST][W+1] && (co_maj_r[LAST] != '0)) ? co_maj_r[LAST][W:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Data registers, all advancing on the common enable.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r  <= s1_s_nxt;
      s1_ad_r <= s1_ad_nxt;
      s1_ay_r <= s1_ay_nxt;
      s1_ys_r <= s1_ys_nxt;
      s1_f_r  <= s1_f_nxt;

      s2_sqd_r <= s1_ad_r * s1_ad_r;
      s2_sqy_r <= s1_ay_r * s1_ay_r;
      s2_s_r   <= s1_s_r;
      s2_ad_r  <= s1_ad_r;
      s2_ys_r  <= s1_ys_r;
      s2_f_r   <= s1_f_r;

      rt_rad_r[0] <= s2_sqd_r + s2_sqy_r;
      rt_rem_r[0] <= '0;
      rt_q_r[0]   <= '0;
      rt_s_r[0]   <= s2_s_r;
      rt_ad_r[0]  <= s2_ad_r;
      rt_ys_r[0]  <= s2_ys_r;
      rt_f_r[0]   <= s2_f_r;
      for (int j = 0; j < K; j++) begin
        rt_rad_r[j+1] <= rt_rad_nxt[j];
        rt_rem_r[j+1] <= rt_rem_nxt[j];
        rt_q_r[j+1]   <= rt_q_nxt[j];
        rt_s_r[j+1]   <= rt_s_r[j];
        rt_ad_r[j+1]  <= rt_ad_r[j];
        rt_ys_r[j+1]  <= rt_ys_r[j];
        rt_f_r[j+1]   <= rt_f_r[j];
      end

      e1_r    <= e1_nxt;
      e2_r    <= e2_nxt;
      re_ad_r <= rt_ad_r[K];
      re_ys_r <= rt_ys_r[K];
      re_f_r  <= rt_f_r[K];

      od_maj_r <= od_maj_nxt;
      od_min_r <= od_min_nxt;
      od_e1m_r <= e1_major_w;
      od_ad_r  <= re_ad_r;
      od_ys_r  <= re_ys_r;
      od_f_r   <= re_f_r;

      co_maj_r[1] <= od_maj_r;
      co_min_r[1] <= od_min_r;
      co_e1m_r[1] <= od_e1m_r;
      co_f_r[1]   <= od_f_r;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        co_x_r[i+1] <= co_x_nxt[i];
        co_y_r[i+1] <= co_y_nxt[i];
        co_z_r[i+1] <= co_z_nxt[i];
      end
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        co_maj_r[i+1] <= co_maj_r[i];
        co_min_r[i+1] <= co_min_r[i];
        co_e1m_r[i+1] <= co_e1m_r[i];
        co_f_r[i+1]   <= co_f_r[i];
      end

      major_r <= co_maj_r[LAST];
      minor_r <= co_min_r[LAST];
      ridge_r <= ridge_nxt;
      angle_r <= angle_nxt;
    end
  end

  assign out_chan.valid            = vld_r[NST-1];
  assign out_chan.major_eigenvalue = major_r;
  assign out_chan.minor_eigenvalue = minor_r;
  assign out_chan.ridge_strength   = ridge_r;
  assign out_chan.normal_angle     = angle_r;

endmodule

// ===== sim/hre_checker.sv =====
// Checker for the Hessian eigen block: predicts each result and compares it with the output.
module hre_checker #(
  parameter int DERIV_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  hre_in_if    in_mon,
  hre_out_if   out_mon,
  output int   errors,
  output int   pending
);
  import hre_pkg::*;

  typedef struct packed {
    logic signed [DERIV_WIDTH+1:0] major;
    logic signed [DERIV_WIDTH+1:0] minor;
    logic        [DERIV_WIDTH:0]   strength;
    logic        [ANGLE_WIDTH-1:0] angle;
  } eigen_t;

  eigen_t eigen_q[$];

  // Closed-form Jacobi rotation with a vectoring CORDIC for the angle.
  function automatic eigen_t solve_hessian(logic signed [DERIV_WIDTH-1:0] yy,
                                           logic signed [DERIV_WIDTH-1:0] xy,
                                           logic signed [DERIV_WIDTH-1:0] xx);
    logic signed [95:0]  s, d, y2, ad, ay, r, lo, hi, e1, e2, m1, m2, big, sml;
    logic signed [95:0]  x, y, z, dx, dy, phi, ang;
    logic        [127:0] sq, c;
    logic        [32:0]  turn;
    logic                e1_hi, e1_major;
    eigen_t              res;
    s  = yy + xx;
    d  = xx - yy;
    y2 = 2 * xy;
    ad = (d < 0) ? -d : d;
    ay = (y2 < 0) ? -y2 : y2;
    sq = ad * ad + ay * ay;
    r  = 0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= sq) r = c;
    end
    lo = (s - r) >>> 1;
    hi = (s + r) >>> 1;
    e1_hi = (d < 0) || (d == 0 && xy < 0);
    e1 = e1_hi ? hi : lo;
    e2 = e1_hi ? lo : hi;
    m1 = (e1 < 0) ? -e1 : e1;
    m2 = (e2 < 0) ? -e2 : e2;
    e1_major = (m1 > m2) || (m1 == m2 && e1 < e2);
    big = e1_major ? e1 : e2;
    sml = e1_major ? e2 : e1;
    if (xy == 0) begin
      phi = 0;
    end else if (d == 0) begin
      phi = 96'sd1 <<< 29;
    end else begin
      // Operands are scaled so the top bit sits at 2^61.
      x = ad <<< (61 - DERIV_WIDTH);
      y = ((d < 0) ? -y2 : y2) <<< (61 - DERIV_WIDTH);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx; y = y - dy; z = z + $signed({64'd0, ATAN_TURNS[i]});
        end else begin
          x = x - dx; y = y + dy; z = z - $signed({64'd0, ATAN_TURNS[i]});
        end
      end
      phi = z >>> 1;
    end
    ang  = e1_major ? phi : phi - (96'sd1 <<< 30);
    turn = {1'b0, ang[31:0]} + (33'd1 << (31 - ANGLE_WIDTH));
    res.major    = big[DERIV_WIDTH+1:0];
    res.minor    = sml[DERIV_WIDTH+1:0];
    res.strength = (big > 0) ? big[DERIV_WIDTH:0] : '0;
    res.angle    = turn[32-ANGLE_WIDTH +: ANGLE_WIDTH];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;
  assign pending = eigen_q.size();

  always @(posedge clk) begin
    eigen_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        eigen_q.insert(eigen_q.size(),
                       solve_hessian(in_mon.second_deriv_yy, in_mon.second_deriv_xy,
                                     in_mon.second_deriv_xx));
      if (out_mon.valid && out_mon.ready) begin
        if (eigen_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = eigen_q.pop_front();
          if (out_mon.major_eigenvalue !== want.major)
            report_mismatch("major", out_mon.major_eigenvalue, want.major);
          if (out_mon.minor_eigenvalue !== want.minor)
            report_mismatch("minor", out_mon.minor_eigenvalue, want.minor);
          if (out_mon.ridge_strength !== want.strength)
            report_mismatch("strength", out_mon.ridge_strength, want.strength);
          if (out_mon.normal_angle !== want.angle)
            report_mismatch("angle", out_mon.normal_angle, want.angle);
        end
      end
    end
  end
endmodule

// ===== sim/hessian_ridge_eigen_tb.sv =====
// Testbench top for the Hessian eigen block: stimulus, receiver stalls and verdict.
module hessian_ridge_eigen_tb;
  localparam int DW = 24;
  localparam int AW = 16;
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   burst_left;

  hre_in_if  #(.DERIV_WIDTH(DW))                   in_chan ();
  hre_out_if #(.DERIV_WIDTH(DW), .ANGLE_WIDTH(AW)) out_chan ();

  hessian_ridge_eigen #(.DERIV_WIDTH(DW), .ANGLE_WIDTH(AW)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  hre_checker #(.DERIV_WIDTH(DW), .ANGLE_WIDTH(AW)) i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one request and holds it until the block takes it. Between requests the
  // sender keeps valid high inside a burst and, at the end of a burst, mostly drops it for a random gap.
  task automatic send_request(logic signed [DW-1:0] yy, logic signed [DW-1:0] xy,
                              logic signed [DW-1:0] xx);
    in_chan.valid           <= 1'b1;
    in_chan.second_deriv_yy <= yy;
    in_chan.second_deriv_xy <= xy;
    in_chan.second_deriv_xx <= xx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Random derivative: mostly full range, sometimes small magnitudes or extremes so
  // that the rounding of small eigenvalues is exercised as well.
  function automatic logic signed [DW-1:0] rand_deriv();
    case ($urandom_range(0, 5))
      0:       return DW'($signed(DW'($urandom_range(0, 64))) - 32);
      1:       return $urandom_range(0, 1) ? DMAX : DMIN;
      2:       return DW'($signed(DW'($urandom_range(0, 1 << 16))) - (1 << 15));
      default: return DW'($urandom());
    endcase
  endfunction

  // The receiver stalls on its own pattern: quiet stretches, light and heavy stalling,
  // and once a long hold-off that lets the pipeline fill and stall the sender.
  initial begin
    int cnt;
    int mode;
    out_chan.ready <= 1'b0;
    cnt = 0;
    mode = 0;
    @(posedge clk);
    while (1) begin
      @(posedge clk);
      cnt++;
      if (cnt == 400) begin
        out_chan.ready <= 1'b0;
        repeat (250) @(posedge clk);
      end
      if (cnt % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       out_chan.ready <= 1'b1;
        1:       out_chan.ready <= ($urandom_range(0, 3) != 0);
        default: out_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    logic signed [DW-1:0] a, b;
    in_chan.valid           <= 1'b0;
    in_chan.second_deriv_yy <= '0;
    in_chan.second_deriv_xy <= '0;
    in_chan.second_deriv_xx <= '0;
    burst_left = 0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: extremes, no cross term, equal diagonals with a cross
    // term of either sign, eigenvalue ties and an angle that rounds to a full turn.
    send_request('0, '0, '0);
    send_request(DMAX, DMAX, DMAX);
    send_request(DMIN, DMIN, DMIN);
    send_request(DMAX, DMIN, DMIN);
    send_request(DMIN, DMAX, DMAX);
    send_request(DMIN, DMIN, DMAX);
    send_request(DMAX, DMAX, DMIN);
    send_request(24'sd4096, '0, 24'sd8192);
    send_request(-24'sd8192, '0, 24'sd4096);
    send_request(24'sd4096, '0, 24'sd4096);
    send_request(-24'sd4096, '0, -24'sd4096);
    send_request(24'sd4096, '0, -24'sd4096);
    send_request(-24'sd4096, '0, 24'sd4096);
    send_request(24'sd1000, 24'sd300, 24'sd1000);
    send_request(24'sd1000, -24'sd300, 24'sd1000);
    send_request('0, -24'sd1, DMAX);
    send_request(DMAX, -24'sd1, '0);
    send_request('0, 24'sd1, DMAX);
    send_request(DMIN, 24'sd1, '0);
    send_request(-24'sd1, -24'sd1, -24'sd1);
    send_request(24'sd1, 24'sd1, -24'sd1);

    repeat (430) begin
      a = rand_deriv();
      b = rand_deriv();
      case ($urandom_range(0, 7))
        0:       send_request(a, '0, b);
        1:       send_request(a, b, a);
        2:       send_request(a, b, -a);
        default: send_request(a, rand_deriv(), b);
      endcase
    end
    in_chan.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
